// ===== design/nec_ir_frame_decoder_defines.svh =====
// Assertion macros shared by the NEC IR frame decoder RTL.
`ifndef NEC_IR_FRAME_DECODER_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge outside reset.
`define NECIR_ASSERT_ALWAYS(label, clock, rstn, cond) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (cond)) \
		else $error("NEC IR decoder invariant violated");

// Check that a condition in one cycle implies another in the same cycle.
`define NECIR_ASSERT_IMPLY(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("NEC IR decoder implication violated");

// Check that a condition in one cycle implies another in the next cycle.
`define NECIR_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("NEC IR decoder sequence violated");

`else

`define NECIR_ASSERT_ALWAYS(label, clock, rstn, cond)
`define NECIR_ASSERT_IMPLY(label, clock, rstn, ante, cons)
`define NECIR_ASSERT_NEXT(label, clock, rstn, ante, cons)

`endif

`endif

// ===== design/necir_pkg.sv =====
// Types, codes and helper functions of the NEC IR frame decoder.
`default_nettype none

package necir_pkg;

	// Decoder phases, one-hot
	typedef enum logic [5:0] {
		PH_IDLE      = 6'b000001,
		PH_CONFIRM   = 6'b000010,
		PH_LEAD_LOW  = 6'b000100,
		PH_LEAD_HIGH = 6'b001000,
		PH_BIT_LOW   = 6'b010000,
		PH_BIT_HIGH  = 6'b100000
	} phase_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_CONFIRM  = 2'd1,
		ST_TIMEOUT     = 2'd2,
		ST_MISMATCH    = 2'd3
	} status_t;

	// Configuration register indexes
	localparam logic [1:0] REG_CONFIRM_TICKS = 2'd0;
	localparam logic [1:0] REG_ONE_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

	// Register reset values
	localparam logic [7:0] CONFIRM_TICKS_RST = 8'd15;
	localparam logic [7:0] ONE_THRESHOLD_RST = 8'd8;
	localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd30;

	localparam int unsigned FRAME_BITS = 32;
	localparam logic [7:0]  TICK_MAX   = 8'hFF;
	localparam logic [6:0]  ASCII_ZERO = 7'h30;
	localparam logic [6:0]  ASCII_ALPHA_OFS = 7'h37;

	// Packed result item, first field in the highest bits
	typedef struct packed {
		logic [6:0] hex_low_char;
		logic [6:0] hex_high_char;
		logic [7:0] command_byte;
		logic [7:0] address_check;
		logic [7:0] address_byte;
		status_t    status;
	} result_t;

	// ASCII hex digit of a nibble: '0'-'9', 'A'-'F'
	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] wide;
		wide = {3'b000, nib};
		return (nib > 4'd9) ? wide + ASCII_ALPHA_OFS : wide + ASCII_ZERO;
	endfunction

endpackage

`default_nettype wire

// ===== design/nec_ir_frame_decoder.sv =====
// NEC infrared remote frame decoder: sample stream in, one result per frame out.
`default_nettype none
`include "nec_ir_frame_decoder_defines.svh"

// Decodes NEC infrared remote frames from a stream of receiver line samples,
// one sample per transfer (s_tdata[0], 1 = line high/idle, 0 = low). A low
// sample in idle starts a frame: the line is rechecked after confirm_ticks
// samples, the leader low and high are skipped, then 32 pulse-distance bits
// are collected LSB first. A bit is a one when its high time reaches
// one_threshold; a high time that reaches timeout_ticks aborts the frame.
// Each started frame yields exactly one result transfer carrying a status
// (0 ok, 1 not confirmed, 2 bit timeout, 3 command/inverse mismatch), the
// address, address check and command bytes, and the command as two ASCII
// hex characters; failed confirm and timeout report zero bytes and '0'
// characters. Leader and bit-low waits have no limit. The block takes one
// sample per clock unless the output stalls it: the sample is held in an
// input register and decoded combinationally into the result register.
// A waiting result in the output register stalls the input only when the
// next sample would itself produce a result. Write configuration registers
// (0 confirm_ticks, 1 one_threshold, 2 timeout_ticks) only while idle.
module nec_ir_frame_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] ir_level, [7:1] zero
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] status, [9:2] address_byte, [17:10] address_check,
	// [25:18] command_byte, [32:26] hex_high_char, [39:33] hex_low_char
	output logic [39:0]      m_tdata,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_wdata
);

	// Configuration registers
	logic [7:0] confirm_ticks_q;
	logic [7:0] one_threshold_q;
	logic [7:0] timeout_ticks_q;

	// Input register
	logic valid_s1;
	logic level_s1;

	// Decoder state
	necir_pkg::phase_t phase_q, phase_d;
	logic [7:0]  tick_q, tick_d, tick_inc;
	logic [5:0]  bit_q, bit_d, bit_inc;
	logic [31:0] frame_q, frame_d;

	// Output register
	logic                out_valid_q;
	necir_pkg::result_t  result_q, result_d;

	logic emit;
	logic fail;
	necir_pkg::status_t fail_code;
	logic out_free;
	logic adv;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_ticks_q <= necir_pkg::CONFIRM_TICKS_RST;
			one_threshold_q <= necir_pkg::ONE_THRESHOLD_RST;
			timeout_ticks_q <= necir_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				necir_pkg::REG_CONFIRM_TICKS: confirm_ticks_q <= cfg_wdata;
				necir_pkg::REG_ONE_THRESHOLD: one_threshold_q <= cfg_wdata;
				necir_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: the held sample advances unless it produces a result while
	// the output register is still occupied and not being drained.
	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (out_free || !emit);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			level_s1 <= s_tdata[0];
		end
	end

	assign tick_inc = (tick_q == necir_pkg::TICK_MAX) ? tick_q : tick_q + 8'd1;
	assign bit_inc  = bit_q + 6'd1;

	// Decode step for one sample
	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		bit_d     = bit_q;
		frame_d   = frame_q;
		emit      = 1'b0;
		fail      = 1'b0;
		fail_code = necir_pkg::ST_NO_CONFIRM;
		case (phase_q)
			necir_pkg::PH_IDLE: begin
				if (!level_s1) begin
					tick_d  = 8'd0;
					bit_d   = 6'd0;
					phase_d = (confirm_ticks_q == 8'd0) ? necir_pkg::PH_LEAD_LOW
					                                    : necir_pkg::PH_CONFIRM;
				end
			end
			necir_pkg::PH_CONFIRM: begin
				tick_d = tick_inc;
				if (tick_inc >= confirm_ticks_q) begin
					if (level_s1) begin
						emit      = 1'b1;
						fail      = 1'b1;
						fail_code = necir_pkg::ST_NO_CONFIRM;
					end else begin
						phase_d = necir_pkg::PH_LEAD_LOW;
					end
				end
			end
			necir_pkg::PH_LEAD_LOW: begin
				if (level_s1) begin
					phase_d = necir_pkg::PH_LEAD_HIGH;
				end
			end
			necir_pkg::PH_LEAD_HIGH: begin
				if (!level_s1) begin
					phase_d = necir_pkg::PH_BIT_LOW;
				end
			end
			necir_pkg::PH_BIT_LOW: begin
				if (level_s1) begin
					tick_d = 8'd1;
					if (timeout_ticks_q <= 8'd1) begin
						emit      = 1'b1;
						fail      = 1'b1;
						fail_code = necir_pkg::ST_TIMEOUT;
					end else begin
						phase_d = necir_pkg::PH_BIT_HIGH;
					end
				end
			end
			necir_pkg::PH_BIT_HIGH: begin
				if (level_s1) begin
					tick_d = tick_inc;
					if (tick_inc >= timeout_ticks_q) begin
						emit      = 1'b1;
						fail      = 1'b1;
						fail_code = necir_pkg::ST_TIMEOUT;
					end
				end else begin
					// End of bit: shift in at the top, LSB-first order
					frame_d = {tick_q >= one_threshold_q, frame_q[31:1]};
					tick_d  = 8'd0;
					bit_d   = bit_inc;
					if (bit_inc[5]) begin
						emit = 1'b1;
					end else begin
						phase_d = necir_pkg::PH_BIT_LOW;
					end
				end
			end
			default: begin
				phase_d = necir_pkg::PH_IDLE;
				tick_d  = 8'd0;
				bit_d   = 6'd0;
			end
		endcase
		// Any result closes the frame
		if (emit) begin
			phase_d = necir_pkg::PH_IDLE;
			tick_d  = 8'd0;
			bit_d   = 6'd0;
		end
	end

	// Assemble the result item
	always_comb begin
		if (fail) begin
			result_d.status        = fail_code;
			result_d.address_byte  = 8'd0;
			result_d.address_check = 8'd0;
			result_d.command_byte  = 8'd0;
			result_d.hex_high_char = necir_pkg::ASCII_ZERO;
			result_d.hex_low_char  = necir_pkg::ASCII_ZERO;
		end else begin
			result_d.status        = (frame_d[23:16] == ~frame_d[31:24])
			                         ? necir_pkg::ST_OK : necir_pkg::ST_MISMATCH;
			result_d.address_byte  = frame_d[7:0];
			result_d.address_check = frame_d[15:8];
			result_d.command_byte  = frame_d[23:16];
			result_d.hex_high_char = necir_pkg::hex_char(frame_d[23:20]);
			result_d.hex_low_char  = necir_pkg::hex_char(frame_d[19:16]);
		end
	end

	// Commit decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= necir_pkg::PH_IDLE;
			tick_q  <= 8'd0;
			bit_q   <= 6'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_q <= frame_d;
		end
	end

	// Output register: load on a new result, clear once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

	// A committed result is presented in the next cycle
	`NECIR_ASSERT_NEXT(a_emit_shows, clk, arst_n, adv && emit, m_tvalid)

	// A stalled sample stays in the input register unchanged
	`NECIR_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv,
		valid_s1 && $stable(level_s1))

	// Idle always starts from a cleared bit counter
	`NECIR_ASSERT_IMPLY(a_idle_clear, clk, arst_n, phase_q == necir_pkg::PH_IDLE,
		bit_q == 6'd0)

	// Failure results carry zero bytes and '0' characters
	`NECIR_ASSERT_IMPLY(a_fail_payload, clk, arst_n,
		m_tvalid && (result_q.status == necir_pkg::ST_NO_CONFIRM ||
			result_q.status == necir_pkg::ST_TIMEOUT),
		result_q.command_byte == 8'd0 && result_q.address_byte == 8'd0 &&
			result_q.hex_low_char == necir_pkg::ASCII_ZERO)

endmodule

`default_nettype wire
